@@ rtl/fully_assoc_lru_tlb_macros.svh @@
// assertion macros used by the port-level checker
`ifndef FULLY_ASSOC_LRU_TLB_MACROS_SVH
`define FULLY_ASSOC_LRU_TLB_MACROS_SVH

// antecedent holds, consequent must hold on the same edge
`define FALT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlb check failed");

// antecedent holds, consequent must hold on the next edge
`define FALT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlb check failed");

`endif

@@ rtl/falt_pkg.sv @@
// shared types and constants of the fully associative lru tlb
package falt_pkg;

    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 54;
    localparam int CNT_W       = 64;
    localparam int LAT_W       = 17;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int SHIFT_W     = 5;
    localparam int ENTRIES_DEF = 64;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd10;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd30;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST   = 5'd13;
    localparam logic [CFG_W-1:0]   HIT_LATENCY_RST  = 16'd0;
    localparam logic [CFG_W-1:0]   MISS_PENALTY_RST = 16'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LATENCY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ENC,
        ST_UPD
    } falt_state_t;

    // strobes from the sequencer to the cell row and the encoder
    typedef struct packed {
        logic cmp;
        logic enc;
        logic upd;
        logic miss;
    } falt_ctrl_t;

endpackage

@@ rtl/fully_assoc_lru_tlb.sv @@
// top level of the fully associative tlb with true lru replacement
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | in        | in_valid / in_ready    | address
//  out     | out       | out_valid / out_ready  | hit, latency, access_count, miss_count
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// an access goes from input transfer to result by latching the page, then the
// tag compare in every cell, then the hit encoder, then the move-to-front
// shift along the cell row and the result load.
// a new access is taken only after the previous one has left the update step.
// the update step waits while the previous result still sits unaccepted.
// reset empties the table at once through the per-cell valid bits; cfg_ready
// is always high.
module fully_assoc_lru_tlb
    import falt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ADDR_W-1:0]    address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [LAT_W-1:0]     latency,
    output logic [CNT_W-1:0]     access_count,
    output logic [CNT_W-1:0]     miss_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);

    // configuration registers
    logic [SHIFT_W-1:0] page_shift_reg;
    logic [CFG_W-1:0]   hit_latency_reg;
    logic [CFG_W-1:0]   miss_penalty_reg;

    // sequencer
    falt_state_t state_reg;
    falt_state_t state_next;
    falt_ctrl_t  ctrl;
    logic        slot_free;
    logic        upd_fire;

    // page of the access in flight
    logic [SHIFT_W-1:0] shift_amt;
    logic [ADDR_W-1:0]  shifted;
    logic [TAG_W-1:0]   page_reg;

    // cell row; index 0 is the most recent entry
    logic [TAG_W-1:0]   tag_w   [ENTRIES];
    logic [ENTRIES-1:0] valid_w;
    logic [ENTRIES-1:0] match_w;

    logic             enc_any;
    logic [IDX_W-1:0] enc_pos;

    // counters and result slot
    logic [CNT_W-1:0] accesses_reg;
    logic [CNT_W-1:0] misses_reg;
    logic             out_valid_reg;
    logic             hit_reg;
    logic [LAT_W-1:0] latency_reg;
    logic [LAT_W-1:0] latency_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg   <= PAGE_SHIFT_RST;
            hit_latency_reg  <= HIT_LATENCY_RST;
            miss_penalty_reg <= MISS_PENALTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PAGE_SHIFT:   page_shift_reg   <= cfg_data[SHIFT_W-1:0];
                CFG_HIT_LATENCY:  hit_latency_reg  <= cfg_data;
                CFG_MISS_PENALTY: miss_penalty_reg <= cfg_data;
                default:          ; // unused index, write dropped
            endcase
        end
    end

    // page shift clamped to the supported page sizes
    always_comb
    begin
        if (page_shift_reg < SHIFT_MIN)
        begin
            shift_amt = SHIFT_MIN;
        end
        else if (page_shift_reg > SHIFT_MAX)
        begin
            shift_amt = SHIFT_MAX;
        end
        else
        begin
            shift_amt = page_shift_reg;
        end
    end

    assign shifted = address >> shift_amt;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            page_reg <= shifted[TAG_W-1:0];
        end
    end

    // result slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_ENC;
            ST_ENC:  state_next = ST_UPD;
            ST_UPD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        ctrl.cmp  = 1'b0;
        ctrl.enc  = 1'b0;
        ctrl.upd  = 1'b0;
        ctrl.miss = !enc_any;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_CMP:  ctrl.cmp = 1'b1;
            ST_ENC:  ctrl.enc = 1'b1;
            ST_UPD:  ctrl.upd = slot_free;
            default: ;
        endcase
    end

    assign upd_fire = ctrl.upd;

    // row of cells; each one takes its lower neighbor's entry on a shift,
    // cell 0 takes the accessed page
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic [TAG_W-1:0] prev_tag;
        logic             prev_valid;

        if (g == 0)
        begin : g_head
            assign prev_tag   = page_reg;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_tag   = tag_w[g-1];
            assign prev_valid = valid_w[g-1];
        end

        falt_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .pos        (enc_pos),
            .page       (page_reg),
            .prev_tag   (prev_tag),
            .prev_valid (prev_valid),
            .tag        (tag_w[g]),
            .valid      (valid_w[g]),
            .match      (match_w[g])
        );
    end

    falt_enc #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_enc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .match (match_w),
        .any   (enc_any),
        .pos   (enc_pos)
    );

    // hit latency, plus miss penalty on a miss
    assign latency_next = {1'b0, hit_latency_reg} +
                          (enc_any ? '0 : {1'b0, miss_penalty_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accesses_reg  <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd_fire)
            begin
                accesses_reg  <= accesses_reg + CNT_W'(1);
                misses_reg    <= misses_reg + {{(CNT_W-1){1'b0}}, !enc_any};
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            hit_reg     <= enc_any;
            latency_reg <= latency_next;
        end
    end

    // counters only move on a result load, so they drive the ports directly
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign latency      = latency_reg;
    assign access_count = accesses_reg;
    assign miss_count   = misses_reg;

endmodule

@@ rtl/falt_cell.sv @@
// one tlb entry: tag, valid, match flag and move-to-front shift
module falt_cell
    import falt_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  falt_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] pos,
    input  logic [TAG_W-1:0] page,
    input  logic [TAG_W-1:0] prev_tag,
    input  logic             prev_valid,
    output logic [TAG_W-1:0] tag,
    output logic             valid,
    output logic             match
);

    logic [TAG_W-1:0] tag_reg;
    logic             valid_reg;
    logic             match_reg;
    logic             shift_en;

    // miss: shift to first empty cell or all when full; hit: shift up to the hit cell
    assign shift_en = ctrl.upd &&
                      (ctrl.miss ? prev_valid : (IDX_W'(CELL_IDX) <= pos));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            tag_reg <= prev_tag;
        end
        if (ctrl.cmp)
        begin
            match_reg <= valid_reg && (tag_reg == page);
        end
    end

    assign tag   = tag_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

@@ rtl/falt_enc.sv @@
// registered encoder: any-hit flag and hit position from the match row
module falt_enc
    import falt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  falt_ctrl_t         ctrl,
    input  logic [ENTRIES-1:0] match,
    output logic               any,
    output logic [IDX_W-1:0]   pos
);

    logic             any_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;

    // tags are unique, so at most one match bit is set and an or works
    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                pos_next = pos_next | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else if (ctrl.enc)
        begin
            any_reg <= |match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.enc)
        begin
            pos_reg <= pos_next;
        end
    end

    assign any = any_reg;
    assign pos = pos_reg;

endmodule

@@ rtl/falt_chk.sv @@
// port-level checker for the tlb and its bind to the top level
`include "fully_assoc_lru_tlb_macros.svh"

module falt_chk
    import falt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 hit,
    input logic [LAT_W-1:0]     latency,
    input logic [CNT_W-1:0]     access_count,
    input logic [CNT_W-1:0]     miss_count,
    input logic                 cfg_ready
);

    // one access at a time: no second transfer right after the first
    `FALT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // a stalled result stays valid and keeps its hit, latency and access count
    `FALT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(hit) && $stable(latency) && $stable(access_count))

    // counters do not move in the cycle after an input transfer
    `FALT_ASSERT_NEXT(a_cnt_quiet, in_valid && in_ready,
        $stable(access_count) && $stable(miss_count))

    // configuration writes are never refused
    `FALT_ASSERT_SAME(a_cfg_always, 1'b1, cfg_ready)

endmodule

bind fully_assoc_lru_tlb falt_chk u_falt_chk (.*);

@@ verif/tlb_result_check.sv @@
// result checker of the tlb: predicts each access reply and compares it with what comes out
module tlb_result_check
    import falt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [ADDR_W-1:0]    address,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 hit,
    input  logic [LAT_W-1:0]     latency,
    input  logic [CNT_W-1:0]     access_count,
    input  logic [CNT_W-1:0]     miss_count,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   pending,
    output int                   fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = ENTRIES_DEF;

    typedef struct packed {
        logic             hit;
        logic [LAT_W-1:0] latency;
        logic [CNT_W-1:0] accesses;
        logic [CNT_W-1:0] misses;
    } tlb_reply_t;

    logic [SHIFT_W-1:0] page_shift_q;
    logic [CFG_W-1:0]   hit_lat_q;
    logic [CFG_W-1:0]   miss_pen_q;
    logic [TAG_W-1:0]   tag_mem [ENTRIES];
    logic               entry_vld [ENTRIES];
    int unsigned        entry_age [ENTRIES];
    logic [CNT_W-1:0]   access_total;
    logic [CNT_W-1:0]   miss_total;
    tlb_reply_t         expected_replies [$];
    tlb_reply_t         want;

    // age every valid entry younger than limit, then slot becomes newest
    function automatic void make_newest(int slot, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (entry_vld[i] && entry_age[i] < limit)
                entry_age[i]++;
        end
        entry_age[slot] = 0;
    endfunction

    function automatic tlb_reply_t lookup_and_update(logic [ADDR_W-1:0] addr);
        logic [SHIFT_W-1:0] sh;
        logic [TAG_W-1:0]   page;
        int                 found;
        int                 empty;
        int                 oldest;
        int unsigned        valid_cnt;
        tlb_reply_t         r;
        sh = page_shift_q;
        if (sh < SHIFT_MIN)
            sh = SHIFT_MIN;
        if (sh > SHIFT_MAX)
            sh = SHIFT_MAX;
        page      = TAG_W'(addr >> sh);
        found     = -1;
        empty     = -1;
        oldest    = 0;
        valid_cnt = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (entry_vld[i])
            begin
                valid_cnt++;
                if (tag_mem[i] == page)
                    found = i;
                if (entry_age[i] > entry_age[oldest] || !entry_vld[oldest])
                    oldest = i;
            end
            else if (empty < 0)
                empty = i;
        end
        access_total++;
        r.hit = (found >= 0);
        if (r.hit)
            make_newest(found, entry_age[found]);
        else
        begin
            miss_total++;
            if (empty >= 0)
            begin
                tag_mem[empty]   = page;
                entry_vld[empty] = 1'b1;
                make_newest(empty, valid_cnt);
            end
            else
            begin
                tag_mem[oldest] = page;
                make_newest(oldest, entry_age[oldest]);
            end
        end
        r.latency = LAT_W'(hit_lat_q);
        if (!r.hit)
            r.latency += LAT_W'(miss_pen_q);
        r.accesses = access_total;
        r.misses   = miss_total;
        return r;
    endfunction

    function automatic void note_mismatch(string field, logic [CNT_W-1:0] exp_v,
                                          logic [CNT_W-1:0] act_v);
        fail_count++;
        $error("%s mismatch: expected %0h, actual %0h", field, exp_v, act_v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_q = PAGE_SHIFT_RST;
            hit_lat_q    = HIT_LATENCY_RST;
            miss_pen_q   = MISS_PENALTY_RST;
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_mem[i]   = '0;
                entry_vld[i] = 1'b0;
                entry_age[i] = 0;
            end
            access_total = '0;
            miss_total   = '0;
            expected_replies.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PAGE_SHIFT:   page_shift_q = cfg_data[SHIFT_W-1:0];
                    CFG_HIT_LATENCY:  hit_lat_q    = cfg_data;
                    CFG_MISS_PENALTY: miss_pen_q   = cfg_data;
                    default:          ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    fail_count++;
                    $error("result transfer with no access outstanding");
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (hit !== want.hit)
                        note_mismatch("hit", CNT_W'(want.hit), CNT_W'(hit));
                    if (latency !== want.latency)
                        note_mismatch("latency", CNT_W'(want.latency), CNT_W'(latency));
                    if (access_count !== want.accesses)
                        note_mismatch("access_count", want.accesses, access_count);
                    if (miss_count !== want.misses)
                        note_mismatch("miss_count", want.misses, miss_count);
                end
            end
            if (in_valid && in_ready)
                expected_replies.push_back(lookup_and_update(address));
            pending <= expected_replies.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// testbench top of the tlb: clock, reset, access and config stimulus, final verdict
module testbench;
    import falt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT     = 200000;  // cycles before the run is declared hung
    localparam int PHASES    = 8;       // random phases, each with its own config
    localparam int POOL_MAX  = 128;

    // index 3 has no register behind it, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // receiver behavior, redrawn at random
    typedef enum logic [1:0] {
        RX_FREE,    // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE,  // ready one cycle in four
        RX_BURST    // ready for a stretch, then stalled for a stretch
    } rx_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [ADDR_W-1:0]    address;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit;
    logic [LAT_W-1:0]     latency;
    logic [CNT_W-1:0]     access_count;
    logic [CNT_W-1:0]     miss_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int pending;     // accesses whose result has not come back yet
    int fail_count;

    // sender burst state
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // page pool for the random phases
    logic [ADDR_W-1:0]  page_pool [POOL_MAX];
    int                 pool_size;
    logic [SHIFT_W-1:0] cur_shift;   // page shift register value as last written

    fully_assoc_lru_tlb u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .latency      (latency),
        .access_count (access_count),
        .miss_count   (miss_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tlb_result_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .latency      (latency),
        .access_count (access_count),
        .miss_count   (miss_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hang guard
    initial
    begin
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // result side: out_ready follows a randomly redrawn mode
    initial
    begin
        rx_mode_t rx_mode;
        int       rx_left;
        int       run_left;
        bit       run_on;
        rx_mode  = RX_FREE;
        rx_left  = 0;
        run_left = 0;
        run_on   = 1'b1;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 80);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    // alternate ready and stalled stretches of random length
                    if (run_left == 0)
                    begin
                        run_on   = ~run_on;
                        run_left = $urandom_range(1, 12);
                    end
                    run_left--;
                    out_ready <= run_on;
                end
            endcase
        end
    end

    // one access transfer; a new burst may start with a gap of idle cycles
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = $urandom_range(1, 6);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // stop sending and wait until every access has its result back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // one register write; only called while the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_PAGE_SHIFT)
            cur_shift = data[SHIFT_W-1:0];
        @(posedge clk);
    endtask

    // address inside the page of base, with a random offset below the page size
    function automatic logic [ADDR_W-1:0] in_page(input logic [ADDR_W-1:0] base);
        logic [SHIFT_W-1:0] sh;
        logic [ADDR_W-1:0]  low_mask;
        sh = cur_shift;
        if (sh < SHIFT_MIN)
            sh = SHIFT_MIN;
        if (sh > SHIFT_MAX)
            sh = SHIFT_MAX;
        low_mask = (64'd1 << sh) - 64'd1;
        return (base & ~low_mask) | ({$urandom, $urandom} & low_mask);
    endfunction

    function automatic logic [CFG_W-1:0] pick_cycles();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [SHIFT_W-1:0] sh;
        int                 n_items;
        int                 sweep_idx;
        int                 pick;
        logic [ADDR_W-1:0]  addr;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        address   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PAGE_SHIFT;
        cfg_data  <= '0;
        cur_shift  = PAGE_SHIFT_RST;
        pool_size  = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // reset config: 8k pages, reset values for hit latency and miss penalty
        gaps_on = 1'b0;
        send_access(64'h0);                      // empty table, first miss
        send_access(64'h1FFF);                   // same page, hit
        send_access('1);                         // top page
        send_access(64'hFFFF_FFFF_FFFF_E000);    // same top page, hit
        send_access(64'h2000);
        wait_idle();

        // largest latencies, shift above the top clamps to 30
        cfg_write(CFG_HIT_LATENCY, '1);
        cfg_write(CFG_MISS_PENALTY, '1);
        cfg_write(CFG_PAGE_SHIFT, 16'd31);
        send_access('1);                         // miss, full 17-bit latency
        send_access(64'hFFFF_FFFF_C000_0000);    // hit on the same 1g page
        wait_idle();

        // shift below the bottom clamps to 10; write to the unused index is dropped
        cfg_write(CFG_PAGE_SHIFT, 16'd0);
        cfg_write(CFG_UNUSED, '1);
        cfg_write(CFG_HIT_LATENCY, '0);
        cfg_write(CFG_MISS_PENALTY, '0);
        send_access(64'h3FF);
        send_access(64'h400);
        send_access(64'h8000_0000_0000_0000);
        wait_idle();

        // upper data bits beyond the 5-bit shift register are masked off (0xa = 10)
        cfg_write(CFG_PAGE_SHIFT, 16'hFFEA);
        cfg_write(CFG_HIT_LATENCY, 16'd7);
        cfg_write(CFG_MISS_PENALTY, 16'd3);
        gaps_on = 1'b1;
        send_access(64'h5555_5555_5555_5555);
        send_access(64'hAAAA_AAAA_AAAA_AAAA);
        send_access(64'h5555_5555_5555_5400);    // hit on the first page
        send_access(64'h400);
        send_access(64'h7FF);
        send_access(64'hFFFF_FFFF_FFFF_FC00);    // largest tag
        send_access('1);
        wait_idle();

        // --- random phases ---
        // mostly reuse of a page pool: a hot set gives hits, cyclic sweeps
        // over pools larger than the table force lru evictions, a small share
        // of fully random addresses adds noise
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       sh = SHIFT_MIN;
                1:       sh = SHIFT_MAX;
                2:       sh = SHIFT_W'($urandom_range(0, 9));
                3:       sh = '1;
                default: sh = SHIFT_W'($urandom_range(10, 30));
            endcase
            cfg_write(CFG_PAGE_SHIFT, {CFG_W'($urandom) & ~CFG_W'({SHIFT_W{1'b1}})} | sh);
            cfg_write(CFG_HIT_LATENCY, pick_cycles());
            cfg_write(CFG_MISS_PENALTY, pick_cycles());
            gaps_on = ($urandom_range(0, 3) != 0);

            if (ph == 0 || $urandom_range(0, 1) == 1)
            begin
                pool_size = $urandom_range(6, 90);
                for (int k = 0; k < pool_size; k++)
                    page_pool[k] = {$urandom, $urandom};
            end

            n_items   = $urandom_range(70, 95);
            sweep_idx = 0;
            repeat (n_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    addr = in_page(page_pool[$urandom_range(0, (pool_size < 8) ?
                                                                pool_size - 1 : 7)]);
                else if (pick < 70)
                    addr = in_page(page_pool[$urandom_range(0, pool_size - 1)]);
                else if (pick < 88)
                begin
                    addr = in_page(page_pool[sweep_idx % pool_size]);
                    sweep_idx++;
                end
                else
                    addr = {$urandom, $urandom};
                send_access(addr);
            end
            wait_idle();
        end

        // let any stray result show up before the verdict
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/falt_pkg.sv
rtl/falt_cell.sv
rtl/falt_enc.sv
rtl/fully_assoc_lru_tlb.sv
rtl/falt_chk.sv
verif/tlb_result_check.sv
verif/testbench.sv
